[src/apts_pkg.sv]
// Shared types and constants for the aging priority task scheduler.
// Used by apts_cell and aging_priority_task_scheduler_unit; depends on nothing.
`default_nettype none

package apts_pkg;

  // operation codes of an input beat
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SETP = 3'd1;
  localparam logic [2:0] OP_DEL  = 3'd2;
  localparam logic [2:0] OP_PICK = 3'd3;
  localparam logic [2:0] OP_TICK = 3'd4;

  // status codes of a result beat
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic signed [5:0] PRIO_MIN  = -6'sd20;
  localparam logic signed [5:0] PRIO_MAX  = 6'sd20;
  localparam logic signed [7:0] DYN_FLOOR = -8'sd128;

  localparam logic [7:0] QUANTUM_RESET = 8'd20;

  // candidate carried around the ring during a pick scan
  typedef struct packed {
    logic              tok;    // this cell holds the scan token
    logic              found;  // a valid task was seen so far
    logic signed [7:0] dyn;    // best dynamic priority so far
  } cand_t;

  // table update broadcast to every cell; the per-cell select picks the target
  typedef struct packed {
    logic              add;
    logic              setp;
    logic              del;
    logic              age;    // age valid tasks, reload the selected winner
    logic signed [5:0] prio;
    logic              cp;
  } cell_cmd_t;

endpackage

`default_nettype wire

[src/apts_cell.sv]
// One task slot of the scheduler ring: entry state plus one stage of the pick scan.
// Depends on apts_pkg.
`default_nettype none

module apts_cell
  import apts_pkg::*;
#(
  parameter int IDX_W = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IDX_W-1:0] index,
  input  wire logic             step,
  input  wire logic             run,
  input  wire logic             inject,
  input  wire cand_t            prev_cand,
  input  wire logic [IDX_W-1:0] prev_idx,
  output cand_t                 cand,
  output logic [IDX_W-1:0]      cand_idx,
  input  wire cell_cmd_t        cmd,
  input  wire logic             sel,
  output logic                  valid,
  output logic                  pflag
);

  logic              valid_q;
  logic signed [5:0] sprio;
  logic signed [7:0] dyn;
  logic              pf;

  logic              in_tok;
  logic              in_found;
  logic signed [7:0] in_dyn;
  logic              take;

  always_comb begin
    in_tok   = inject | (run & prev_cand.tok);
    in_found = inject ? 1'b0 : prev_cand.found;
    in_dyn   = prev_cand.dyn;
    // strict compare keeps the earlier slot in circular order on a tie
    take     = in_tok && valid_q && (!in_found || (dyn < in_dyn));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand <= '0;
    end else if (step) begin
      cand.tok   <= in_tok;
      cand.found <= in_found | take;
      cand.dyn   <= take ? dyn : in_dyn;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      cand_idx <= take ? index : prev_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (sel && cmd.add) begin
      valid_q <= 1'b1;
    end else if (sel && cmd.del) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.add) begin
      sprio <= cmd.prio;
      dyn   <= 8'(cmd.prio);
      pf    <= cmd.cp;
    end else if (sel && cmd.setp) begin
      sprio <= cmd.prio;
      dyn   <= 8'(cmd.prio);
    end else if (cmd.age && valid_q) begin
      // winner restarts at its static priority, the rest age toward the floor
      if (sel) begin
        dyn <= 8'(sprio);
      end else if (dyn != DYN_FLOOR) begin
        dyn <= dyn - 8'sd1;
      end
    end
  end

  assign valid = valid_q;
  assign pflag = pf;

endmodule

`default_nettype wire

[src/aging_priority_task_scheduler_unit.sv]
// Top level of the aging priority task scheduler: control, output register and cell ring.
// Depends on apts_pkg and apts_cell.
//
// Usage: commands arrive as beats on s_tvalid/s_tready/s_tdata; each gives
// exactly one result beat on m_tvalid/m_tready/m_tdata. The quantum register
// is written on cfg_valid/cfg_ready/cfg_data; the user must write it only while
// the block is idle, and the block itself does not enforce this. One command
// is in work at a time. Add, set priority, remove, tick and unused codes are
// registered at the input beat and give their result in the EXEC state. A pick
// sends a token once around the ring of MAX_TASKS cells, one cell per cycle,
// and gives its result in the FINISH state once every cell has seen the token.
// The next command is taken while a result still waits in the output
// register; it is then held until m_tready frees that register.
// Reset empties the task table, clears the current task and the quantum
// counter, and loads a quantum of 20 ticks; the table needs no clearing pass.
// A stalled receiver holds m_tdata steady and stops further results.
`default_nettype none

module aging_priority_task_scheduler_unit
  import apts_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // op[2:0], slot[6:3], prio[12:7], can_preempt[13], zero
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // status[1:0], chosen_slot[5:2], preempt[6], zero
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  localparam int IDX_W = $clog2(MAX_TASKS);

  typedef enum logic [1:0] {IDLE, EXEC, SCAN, FINISH} state_t;

  state_t            state;
  logic [2:0]        op_q;
  logic [3:0]        slot_q;
  logic signed [5:0] prio_q;
  logic              cp_q;
  logic [IDX_W-1:0]  cnt;
  logic [IDX_W-1:0]  last_chosen;
  logic              current_valid;
  logic [7:0]        quantum_left;
  logic [7:0]        quantum_ticks;

  cand_t             cand     [MAX_TASKS];
  logic [IDX_W-1:0]  cand_idx [MAX_TASKS];
  logic [MAX_TASKS-1:0] v;
  logic [MAX_TASKS-1:0] pf;
  logic [MAX_TASKS-1:0] sel;

  logic              out_free;
  logic              prio_ok;
  logic              in_table;
  logic [IDX_W-1:0]  slot_idx;
  logic              slot_v;
  logic              found;
  logic [IDX_W-1:0]  best_idx;
  logic              inject;
  logic              run;
  logic              step;
  logic              commit;
  cell_cmd_t         cmd;
  logic [1:0]        res_status;
  logic [3:0]        res_chosen;
  logic              res_preempt;
  logic [7:0]        ql_dec;
  logic              cv_next;
  logic [7:0]        ql_next;

  assign s_tready  = (state == IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    prio_ok  = (prio_q >= PRIO_MIN) && (prio_q <= PRIO_MAX);
    in_table = 32'(slot_q) < MAX_TASKS;
    slot_idx = IDX_W'(slot_q);
    slot_v   = in_table && v[slot_idx];
  end

  // the scan token sits in exactly one cell once the pick has started
  always_comb begin
    found    = 1'b0;
    best_idx = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (cand[i].tok) begin
        found    = found | cand[i].found;
        best_idx = best_idx | cand_idx[i];
      end
    end
  end

  always_comb begin
    inject = (state == EXEC) && (op_q == OP_PICK);
    run    = (state == SCAN);
    step   = inject | run;
    commit = ((state == EXEC) && (op_q != OP_PICK) && out_free)
          || ((state == FINISH) && out_free);
    cmd.add  = commit && (state == EXEC) && (op_q == OP_ADD) && prio_ok;
    cmd.setp = commit && (state == EXEC) && (op_q == OP_SETP) && prio_ok && slot_v;
    cmd.del  = commit && (state == EXEC) && (op_q == OP_DEL) && slot_v;
    cmd.age  = commit && (state == FINISH) && found;
    cmd.prio = prio_q;
    cmd.cp   = cp_q;
    for (int i = 0; i < MAX_TASKS; i++) begin
      sel[i] = (state == FINISH) ? (best_idx == IDX_W'(i))
                                 : (in_table && (slot_idx == IDX_W'(i)));
    end
  end

  always_comb begin
    res_status  = ST_OK;
    res_chosen  = 4'd0;
    res_preempt = 1'b0;
    cv_next     = current_valid;
    ql_next     = quantum_left;
    ql_dec      = (quantum_left == 8'd0) ? 8'd0 : quantum_left - 8'd1;
    if (state == FINISH) begin
      if (found) begin
        res_chosen = 4'(best_idx);
        cv_next    = 1'b1;
        ql_next    = quantum_ticks;
      end else begin
        res_status = ST_EMPTY;
      end
    end else begin
      case (op_q)
        OP_ADD: begin
          if (!prio_ok) begin
            res_status = ST_RANGE;
          end else if (!in_table) begin
            res_status = ST_EMPTY;
          end
        end
        OP_SETP: begin
          if (!prio_ok) begin
            res_status = ST_RANGE;
          end else if (!slot_v) begin
            res_status = ST_EMPTY;
          end
        end
        OP_DEL: begin
          if (!slot_v) begin
            res_status = ST_EMPTY;
          end else if (current_valid && (last_chosen == slot_idx)) begin
            cv_next = 1'b0;
          end
        end
        OP_TICK: begin
          if (!current_valid) begin
            res_status = ST_EMPTY;
          end else if (pf[last_chosen]) begin
            ql_next = ql_dec;
            if (ql_dec == 8'd0) begin
              res_preempt = 1'b1;
              cv_next     = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      cnt           <= '0;
      last_chosen   <= '0;
      current_valid <= 1'b0;
      quantum_left  <= 8'd0;
      quantum_ticks <= QUANTUM_RESET;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        quantum_ticks <= cfg_data;
      end
      if (commit) begin
        m_tvalid      <= 1'b1;
        m_tdata       <= {1'b0, res_preempt, res_chosen, res_status};
        current_valid <= cv_next;
        quantum_left  <= ql_next;
        if (cmd.age) begin
          last_chosen <= best_idx;
        end
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          if (op_q == OP_PICK) begin
            cnt   <= '0;
            state <= SCAN;
          end else if (out_free) begin
            state <= IDLE;
          end
        end
        SCAN: begin
          // advance the token until every cell has seen it
          if (cnt == IDX_W'(MAX_TASKS - 2)) begin
            state <= FINISH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        FINISH: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q   <= s_tdata[2:0];
      slot_q <= s_tdata[6:3];
      prio_q <= s_tdata[12:7];
      cp_q   <= s_tdata[13];
    end
  end

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    localparam int PREV = (i + MAX_TASKS - 1) % MAX_TASKS;
    apts_cell #(
      .IDX_W(IDX_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .index    (IDX_W'(i)),
      .step     (step),
      .run      (run),
      .inject   (inject && (last_chosen == IDX_W'(i))),
      .prev_cand(cand[PREV]),
      .prev_idx (cand_idx[PREV]),
      .cand     (cand[i]),
      .cand_idx (cand_idx[i]),
      .cmd      (cmd),
      .sel      (sel[i]),
      .valid    (v[i]),
      .pflag    (pf[i])
    );
  end

  logic [MAX_TASKS-1:0] tok_vec;
  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      tok_vec[i] = cand[i].tok;
    end
  end

  a_token_unique: assert property (@(posedge clk) disable iff (rst) $onehot0(tok_vec))
    else $error("scan token present in more than one cell");

  a_current_live: assert property (@(posedge clk) disable iff (rst)
    current_valid |-> v[last_chosen])
    else $error("current task points at an empty slot");

  a_scan_token: assert property (@(posedge clk) disable iff (rst)
    (state == FINISH) |-> $onehot(tok_vec))
    else $error("pick finished without a scan token");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != 2'd3))
    else $error("undefined status code on result");

endmodule

`default_nettype wire
